// ----- hdl/tts_pkg.sv -----
// Shared types and constants of the transposition table store.
// Used by every module of the block; depends on nothing.
package tts_pkg;

	localparam int unsigned KEY_W         = 64;
	localparam int unsigned DIV_W         = 13;
	localparam int unsigned CFG_DATA_W    = 15;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned TT_DEPTH_DEF  = 4096;
	localparam int unsigned MATE_WINDOW   = 50;

	// function codes
	localparam logic [1:0] FUNC_PROBE  = 2'd0;
	localparam logic [1:0] FUNC_RECORD = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	// bound kinds
	localparam logic [1:0] KIND_UNKNOWN = 2'd0;
	localparam logic [1:0] KIND_UPPER   = 2'd1;
	localparam logic [1:0] KIND_LOWER   = 2'd2;
	localparam logic [1:0] KIND_EXACT   = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AGE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MATE    = 2'd2;

	// configuration reset values
	localparam logic [DIV_W-1:0] ENTRIES_RST = 13'd4096;
	localparam logic [3:0]       AGE_RST     = 4'd0;
	localparam logic [14:0]      MATE_RST    = 15'd32000;

	typedef struct packed {
		logic [1:0]         func;
		logic [KEY_W-1:0]   key;
		logic [31:0]        move_code;
		logic signed [7:0]  search_depth;
		logic signed [15:0] score;
		logic [1:0]         bound_kind;
		logic [6:0]         ply_from_root;
	} in_item_t;

	typedef struct packed {
		logic               hit;
		logic [31:0]        found_move;
		logic signed [7:0]  found_depth;
		logic signed [15:0] found_score;
		logic [1:0]         found_kind;
		logic               written;
	} out_item_t;

	// stored payload, age in the top bits
	typedef struct packed {
		logic [3:0]         age;
		logic [1:0]         kind;
		logic signed [15:0] score;
		logic signed [7:0]  depth;
		logic [31:0]        move;
	} payload_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		payload_t         pl;
	} entry_t;

	typedef struct packed {
		logic replace;
		payload_t pl;
	} policy_t;

endpackage

// ----- hdl/tts_divider.sv -----
// Restoring remainder unit: 64-bit key modulo a 13-bit divisor, one bit per cycle.
// Depends on tts_pkg.
module tts_divider import tts_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] rem
);

	localparam int unsigned CNT_W = $clog2(KEY_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [KEY_W-1:0] shift_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] div_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             fits;

	// partial remainder stays below the divisor, so the trial fits one extra bit
	assign trial = {rem_q, shift_q[KEY_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(KEY_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			div_q   <= divisor;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[KEY_W-2:0], 1'b0};
			rem_q   <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ----- hdl/tts_policy.sv -----
// Replacement decision and mate score adjustment for a record transaction.
// Depends on tts_pkg.
module tts_policy import tts_pkg::*; (
	input  in_item_t    item,
	input  payload_t    stored,
	input  logic [3:0]  age,
	input  logic [14:0] mate,
	output policy_t     pol
);

	logic signed [17:0] sc;
	logic signed [17:0] mv;
	logic signed [17:0] ply;
	logic signed [17:0] win;
	logic signed [17:0] adj;
	logic signed [15:0] sat;
	logic               ok;

	always_comb begin
		sc  = 18'(item.score);
		mv  = signed'({3'b000, mate});
		ply = signed'({11'd0, item.ply_from_root});
		win = 18'(MATE_WINDOW);
		// positive window wins when the two overlap
		if (sc > mv - win && sc <= mv) begin
			adj = sc + ply;
		end else if (sc < win - mv && sc >= -mv) begin
			adj = sc - ply;
		end else begin
			adj = sc;
		end
		if (adj > 18'sd32767) begin
			sat = 16'sh7fff;
		end else if (adj < -18'sd32768) begin
			sat = -16'sd32768;
		end else begin
			sat = adj[15:0];
		end
	end

	always_comb begin
		if (stored.age != age) begin
			ok = 1'b1;
		end else if (stored.kind == KIND_UNKNOWN) begin
			ok = 1'b1;
		end else if (item.bound_kind == KIND_UNKNOWN) begin
			ok = 1'b0;
		end else begin
			ok = (item.bound_kind > stored.kind) ||
				(item.bound_kind == stored.kind && item.search_depth >= stored.depth);
		end
	end

	always_comb begin
		pol.replace  = ok;
		pol.pl.age   = age;
		pol.pl.kind  = item.bound_kind;
		pol.pl.score = sat;
		pol.pl.depth = item.search_depth;
		pol.pl.move  = item.move_code;
	end

endmodule

// ----- hdl/transposition_table_store_top.sv -----
// Top level of the transposition table store: sequencer, slot memory, config.
// Depends on tts_pkg, tts_divider and tts_policy.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one transaction: a probe,
//   a record or a clear. Output channel out_valid/out_ready/out_data returns
//   exactly one result per input transaction, in order.
//   Probe and record go from accept to result in steps: the slot index is
//   key modulo entries_in_use, formed one dividend bit per cycle by the shared
//   remainder unit, then the slot is captured, the memory is read, the
//   decision/write is made and the result goes into the output register.
//   A clear walks the memory one slot per cycle. Function code 3 touches no
//   memory and returns an all-zero result.
//   One transaction is in flight at a time; in_ready is high only when idle.
//   After reset the block sweeps all TABLE_DEPTH slots to zero with in_ready
//   low; configuration writes are taken at any time.
//   A finished result sits in the output register; while the receiver stalls
//   a new transaction may still be taken, but its result waits until the
//   output register is free.
//   Write configuration only while no transaction is outstanding.
module transposition_table_store_top import tts_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TT_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned SW    = (IDX_W > DIV_W) ? IDX_W : DIV_W;
	localparam int unsigned CAP   = (TABLE_DEPTH > 8191) ? 8191 : TABLE_DEPTH;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_EXEC  = 3'd4;
	localparam logic [2:0] ST_WIPE  = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] slot_q;
	in_item_t         item_q;
	out_item_t        res_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic [DIV_W-1:0] entries_q;
	logic [3:0]       age_q;
	logic [14:0]      mate_q;

	entry_t           slots_q [TABLE_DEPTH];
	entry_t           rd_q;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;

	logic             accept;
	logic             div_start;
	logic             div_done;
	logic [DIV_W-1:0] div_rem;
	logic [DIV_W-1:0] divisor;
	logic [SW-1:0]    rem_wide;
	logic             sweep_last;
	logic             load_out;
	policy_t          pol;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign div_start  = accept &&
		(in_data.func == FUNC_PROBE || in_data.func == FUNC_RECORD);
	assign sweep_last = (clr_q == IDX_W'(TABLE_DEPTH - 1));
	assign load_out   = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign rem_wide   = SW'(div_rem);

	// out-of-range counts act as the nearest legal one
	always_comb begin
		if (entries_q == '0) begin
			divisor = DIV_W'(1);
		end else if (entries_q > DIV_W'(CAP)) begin
			divisor = DIV_W'(CAP);
		end else begin
			divisor = entries_q;
		end
	end

	tts_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (in_data.key),
		.divisor  (divisor),
		.done     (div_done),
		.rem      (div_rem)
	);

	tts_policy u_pol (
		.item   (item_q),
		.stored (rd_q.pl),
		.age    (age_q),
		.mate   (mate_q),
		.pol    (pol)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ENTRIES_RST;
			age_q     <= AGE_RST;
			mate_q    <= MATE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENTRIES: entries_q <= cfg_data[DIV_W-1:0];
				REG_AGE:     age_q     <= cfg_data[3:0];
				REG_MATE:    mate_q    <= cfg_data[14:0];
				default:     ;
			endcase
		end
	end

	// memory write port: sweep or record
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_q;
		mem_wdata = '0;
		if (state_q == ST_CLEAR || state_q == ST_WIPE) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
		end else if (state_q == ST_EXEC && item_q.func == FUNC_RECORD && pol.replace) begin
			mem_we        = 1'b1;
			mem_wdata.key = item_q.key;
			mem_wdata.pl  = pol.pl;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slots_q[mem_waddr] <= mem_wdata;
		end
		rd_q <= slots_q[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR, ST_WIPE: begin
					clr_q <= clr_q + IDX_W'(1);
					if (sweep_last) begin
						clr_q   <= '0;
						state_q <= (state_q == ST_CLEAR) ? ST_IDLE : ST_FIN;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						priority if (div_start) begin
							state_q <= ST_DIV;
						end else if (in_data.func == FUNC_CLEAR) begin
							clr_q   <= '0;
							state_q <= ST_WIPE;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_EXEC;
				ST_EXEC: state_q <= ST_FIN;
				ST_FIN: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
			res_q  <= '0;
		end
		if (state_q == ST_DIV && div_done) begin
			slot_q <= rem_wide[IDX_W-1:0];
		end
		if (state_q == ST_EXEC) begin
			if (item_q.func == FUNC_PROBE) begin
				if (rd_q.key == item_q.key) begin
					res_q.hit         <= 1'b1;
					res_q.found_move  <= rd_q.pl.move;
					res_q.found_depth <= rd_q.pl.depth;
					res_q.found_score <= rd_q.pl.score;
					res_q.found_kind  <= rd_q.pl.kind;
				end
			end else begin
				res_q.written <= pol.replace;
			end
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- hdl/tts_checker.sv -----
// Port-level checks of the transposition table store, bound to its top level.
// Depends on tts_pkg and transposition_table_store_top.
module tts_checker import tts_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input in_item_t              in_data,
	input logic                  out_valid,
	input logic                  out_ready,
	input out_item_t             out_data,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// one transaction in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after an accept");

	// clearing sweep keeps the input closed right after reset
	a_reset_sweep: assert property (@(posedge clk)
		!arst_n |=> !in_ready)
		else $error("input open during clearing sweep");

	// no result can appear the cycle after an accept
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind transposition_table_store_top tts_checker u_chk (.*);
